// File: sv/vafd_pkg.sv
// ----------------------------------------------------------------------------
// vafd_pkg
// Shared codes, types and helpers for the vertex attribute format decoder.
// ----------------------------------------------------------------------------
package vafd_pkg;

   localparam int unsigned NUM_LANES = 4;
   localparam int unsigned FRAC_W    = 48;

   localparam logic [31:0] FMT_UNORM_16_16   = 32'h0000_0007;
   localparam logic [31:0] FMT_SNORM_16_16   = 32'h0000_0207;
   localparam logic [31:0] FMT_UNORM_8X4     = 32'h0000_000A;
   localparam logic [31:0] FMT_SNORM_8X4     = 32'h0000_020A;
   localparam logic [31:0] FMT_SNORM_10_10_2 = 32'h0000_020B;
   localparam logic [31:0] FMT_HALF_16_16    = 32'h0000_080D;
   localparam logic [31:0] FMT_HALF_16X4     = 32'h0000_080F;
   localparam logic [31:0] FMT_FLOAT_32X2    = 32'h0000_0806;
   localparam logic [31:0] FMT_FLOAT_32X3    = 32'h0000_0811;
   localparam logic [31:0] FMT_FLOAT_32X4    = 32'h0000_0813;

   localparam logic [31:0] ONE_BITS      = 32'h3F80_0000;
   localparam logic [31:0] HALF_INF_BITS = 32'h7149_F2CA;

   localparam logic [1:0] LM_PASS = 2'd0;
   localparam logic [1:0] LM_HALF = 2'd1;
   localparam logic [1:0] LM_DIV  = 2'd2;

   localparam logic [2:0] WS_S7  = 3'd0;
   localparam logic [2:0] WS_U8  = 3'd1;
   localparam logic [2:0] WS_S9  = 3'd2;
   localparam logic [2:0] WS_S15 = 3'd3;
   localparam logic [2:0] WS_U16 = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  wsel;
      logic [31:0] raw;
   } lane_ctl_type;

   // The quotient r / (2^b - 1) is the b-bit block r repeated forever.
   function automatic logic [FRAC_W-1:0] frac_rep(input logic [15:0] r,
                                                  input logic [2:0] wsel);
      logic [FRAC_W-1:0] f;
      f = '0;
      case (wsel)
         WS_S7: begin
            for (int i = 0; i < FRAC_W; i++) f[FRAC_W-1-i] = r[6 - (i % 7)];
         end
         WS_U8: begin
            for (int i = 0; i < FRAC_W; i++) f[FRAC_W-1-i] = r[7 - (i % 8)];
         end
         WS_S9: begin
            for (int i = 0; i < FRAC_W; i++) f[FRAC_W-1-i] = r[8 - (i % 9)];
         end
         WS_S15: begin
            for (int i = 0; i < FRAC_W; i++) f[FRAC_W-1-i] = r[14 - (i % 15)];
         end
         WS_U16: begin
            for (int i = 0; i < FRAC_W; i++) f[FRAC_W-1-i] = r[15 - (i % 16)];
         end
         default: f = '0;
      endcase
      return f;
   endfunction

endpackage

// File: sv/vafd_if.sv
// ----------------------------------------------------------------------------
// vafd request and response channels
// Valid/ready channels that carry one attribute request and one result.
// ----------------------------------------------------------------------------
interface vafd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] format_code;
   logic [63:0] bytes_high;
   logic [63:0] bytes_low;
   logic [4:0]  bytes_available;

   modport source (output valid, format_code, bytes_high, bytes_low, bytes_available,
                   input ready);
   modport sink (input valid, format_code, bytes_high, bytes_low, bytes_available,
                 output ready);
endinterface

interface vafd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] comp_x;
   logic [31:0] comp_y;
   logic [31:0] comp_z;
   logic [31:0] comp_w;
   logic        recognized;

   modport source (output valid, comp_x, comp_y, comp_z, comp_w, recognized,
                   input ready);
   modport sink (input valid, comp_x, comp_y, comp_z, comp_w, recognized,
                 output ready);
endinterface

// File: sv/vertex_attribute_format_decoder_core.sv
// ----------------------------------------------------------------------------
// vertex_attribute_format_decoder_core
// Pipeline: two lane register stages between request and response.
// Throughput: one request per cycle; the lane pipeline stalls as a whole
// only while a finished response is not taken.
// Reset: synchronous, clears the pipeline valid flags; no other state.
// ----------------------------------------------------------------------------
module vertex_attribute_format_decoder_core (
   input  logic        clock,
   input  logic        reset,
   vafd_req_if.sink    req_ch,
   vafd_rsp_if.source  rsp_ch
);
   import vafd_pkg::*;

   logic v1_ff, v1_in, v2_ff, v2_in;
   logic rec1_ff, rec2_ff, rec_in;
   logic [NUM_LANES-1:0] used1_ff, used2_ff, used_in;
   logic advance;

   lane_ctl_type [NUM_LANES-1:0] ctl;
   logic [NUM_LANES-1:0][31:0]  lane_result;
   logic [NUM_LANES-1:0][31:0]  comp;
   logic [127:0] bytes;
   logic [31:0]  word0;
   logic [4:0]   need;
   logic         known;

   assign advance = !v2_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   always_comb begin
      bytes = {req_ch.bytes_high, req_ch.bytes_low};
      word0 = bytes[127:96];
      known = 1'b1;
      need = 5'd4;
      used_in = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         ctl[i].mode = LM_PASS;
         ctl[i].wsel = WS_U16;
         ctl[i].raw = bytes[127-32*i -: 32];
      end
      case (req_ch.format_code)
         FMT_UNORM_16_16, FMT_SNORM_16_16: begin
            used_in = 4'b0011;
            for (int i = 0; i < 2; i++) begin
               ctl[i].mode = LM_DIV;
               ctl[i].wsel = (req_ch.format_code == FMT_SNORM_16_16) ? WS_S15 : WS_U16;
               ctl[i].raw = {16'd0, bytes[127-16*i -: 16]};
            end
         end
         FMT_UNORM_8X4, FMT_SNORM_8X4: begin
            used_in = 4'b1111;
            for (int i = 0; i < NUM_LANES; i++) begin
               ctl[i].mode = LM_DIV;
               ctl[i].wsel = (req_ch.format_code == FMT_SNORM_8X4) ? WS_S7 : WS_U8;
               ctl[i].raw = {24'd0, bytes[127-8*i -: 8]};
            end
         end
         FMT_SNORM_10_10_2: begin
            used_in = 4'b0111;
            for (int i = 0; i < 3; i++) begin
               ctl[i].mode = LM_DIV;
               ctl[i].wsel = WS_S9;
               ctl[i].raw = {22'd0, word0[10*i +: 10]};
            end
         end
         FMT_HALF_16_16, FMT_HALF_16X4: begin
            used_in = (req_ch.format_code == FMT_HALF_16X4) ? 4'b1111 : 4'b0011;
            need = (req_ch.format_code == FMT_HALF_16X4) ? 5'd8 : 5'd4;
            for (int i = 0; i < NUM_LANES; i++) begin
               ctl[i].mode = LM_HALF;
               ctl[i].raw = {16'd0, bytes[127-16*i -: 16]};
            end
         end
         FMT_FLOAT_32X2: begin
            used_in = 4'b0011;
            need = 5'd8;
         end
         FMT_FLOAT_32X3: begin
            used_in = 4'b0111;
            need = 5'd12;
         end
         FMT_FLOAT_32X4: begin
            used_in = 4'b1111;
            need = 5'd16;
         end
         default: begin
            known = 1'b0;
         end
      endcase
      rec_in = known && (req_ch.bytes_available >= need);
      if (!rec_in) used_in = '0;
   end

   assign v1_in = advance ? req_ch.valid : v1_ff;
   assign v2_in = advance ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rec1_ff <= rec_in;
         rec2_ff <= rec1_ff;
         used1_ff <= used_in;
         used2_ff <= used1_ff;
      end
   end

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      vafd_lane u_lane (
         .clock  (clock),
         .enable (advance),
         .ctl    (ctl[g]),
         .result (lane_result[g])
      );
   end

   vafd_merge u_merge (
      .lane_result (lane_result),
      .lane_used   (used2_ff),
      .comp        (comp)
   );

   assign rsp_ch.valid = v2_ff;
   assign rsp_ch.comp_x = comp[0];
   assign rsp_ch.comp_y = comp[1];
   assign rsp_ch.comp_z = comp[2];
   assign rsp_ch.comp_w = comp[3];
   assign rsp_ch.recognized = rec2_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> v1_ff)
      else $error("accepted request did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !rsp_ch.ready |=> v2_ff && $stable(rec2_ff))
      else $error("stalled response was lost");

   a_default_comps: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !rec2_ff |-> rsp_ch.comp_w == ONE_BITS && rsp_ch.comp_x == 32'd0)
      else $error("unrecognized response lacks default components");

   a_used_needs_rec: assert property (@(posedge clock) disable iff (reset)
      v2_ff && used2_ff != '0 |-> rec2_ff)
      else $error("lane used for an unrecognized request");

endmodule

// File: sv/vafd_lane.sv
// ----------------------------------------------------------------------------
// vafd_lane
// One component converter: normalized division, half widening or pass.
// ----------------------------------------------------------------------------
module vafd_lane (
   input  logic                  clock,
   input  logic                  enable,
   input  vafd_pkg::lane_ctl_type ctl,
   output logic [31:0]           result
);
   import vafd_pkg::*;

   logic [1:0]        mode_ff;
   logic [31:0]       raw_ff;
   logic              sgn_ff, sgn_in;
   logic              zero_ff, zero_in;
   logic              whole_ff, whole_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [4:0]        lz_ff, lz_in;
   logic              sticky_ff, sticky_in;
   logic [31:0]       result_ff, result_in;

   logic [15:0] val, mag, dv, rem;

   always_comb begin
      val = ctl.raw[15:0];
      sgn_in = 1'b0;
      mag = val;
      dv = 16'hFFFF;
      case (ctl.wsel)
         WS_S7: begin
            sgn_in = val[7];
            mag = sgn_in ? 16'(9'h100 - {1'b0, val[7:0]}) : {8'b0, val[7:0]};
            dv = 16'd127;
         end
         WS_U8: begin
            mag = {8'b0, val[7:0]};
            dv = 16'd255;
         end
         WS_S9: begin
            sgn_in = val[9];
            mag = sgn_in ? 16'(11'h400 - {1'b0, val[9:0]}) : {6'b0, val[9:0]};
            dv = 16'd511;
         end
         WS_S15: begin
            sgn_in = val[15];
            mag = sgn_in ? 16'(17'h10000 - {1'b0, val}) : val;
            dv = 16'd32767;
         end
         default: begin
            mag = val;
            dv = 16'hFFFF;
         end
      endcase
      whole_in = (mag >= dv);
      rem = whole_in ? 16'(mag - dv) : mag;
      frac_in = frac_rep(rem, ctl.wsel);
      lz_in = 5'd0;
      for (int k = 0; k < 16; k++) begin
         if (frac_in[FRAC_W-16+k]) lz_in = 5'(15 - k);
      end
      sticky_in = (rem != 16'd0);
      zero_in = (mag == 16'd0);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mode_ff <= ctl.mode;
         raw_ff <= ctl.raw;
         sgn_ff <= sgn_in;
         zero_ff <= zero_in;
         whole_ff <= whole_in;
         frac_ff <= frac_in;
         lz_ff <= lz_in;
         sticky_ff <= sticky_in;
      end
   end

   logic [FRAC_W-1:0] shifted;
   logic [30:0]       body, rounded;
   logic              guard, inc;
   logic [4:0]        hex;
   logic [9:0]        hman;
   logic [3:0]        hk;
   logic [32:0]       hsub;
   logic [31:0]       half_val;

   always_comb begin
      shifted = frac_ff << (lz_ff + 5'd1);
      if (whole_ff) begin
         body = {8'd127, frac_ff[FRAC_W-1:FRAC_W-23]};
         guard = frac_ff[FRAC_W-24];
      end else begin
         body = {8'(8'd126 - {3'b0, lz_ff}), shifted[FRAC_W-1:FRAC_W-23]};
         guard = shifted[FRAC_W-24];
      end
      inc = guard & (sticky_ff | body[0]);
      rounded = body + {30'b0, inc};

      hex = raw_ff[14:10];
      hman = raw_ff[9:0];
      hk = 4'd0;
      for (int k = 0; k < 10; k++) begin
         if (hman[k]) hk = 4'(k);
      end
      hsub = {23'b0, hman} << (5'd23 - {1'b0, hk});
      if (hex == 5'd0) begin
         half_val = (hman == 10'd0) ? {raw_ff[15], 31'd0}
                  : {raw_ff[15], 8'(8'd103 + {4'b0, hk}), hsub[22:0]};
      end else if (hex == 5'd31) begin
         half_val = (hman != 10'd0) ? {raw_ff[15], 31'd0}
                  : {raw_ff[15], HALF_INF_BITS[30:0]};
      end else begin
         half_val = {raw_ff[15], 8'({3'b0, hex} + 8'd112), hman, 13'd0};
      end

      case (mode_ff)
         LM_DIV:  result_in = zero_ff ? 32'd0 : {sgn_ff, rounded};
         LM_HALF: result_in = half_val;
         default: result_in = raw_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: sv/vafd_merge.sv
// ----------------------------------------------------------------------------
// vafd_merge
// Combines the lane results with the default components into one response.
// ----------------------------------------------------------------------------
module vafd_merge (
   input  logic [vafd_pkg::NUM_LANES-1:0][31:0] lane_result,
   input  logic [vafd_pkg::NUM_LANES-1:0]       lane_used,
   output logic [vafd_pkg::NUM_LANES-1:0][31:0] comp
);
   import vafd_pkg::*;

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         if (lane_used[i]) begin
            comp[i] = lane_result[i];
         end else begin
            comp[i] = (i == NUM_LANES - 1) ? ONE_BITS : 32'd0;
         end
      end
   end

endmodule
